// ===== rtl/broadcast_tree_schedule_unit_defines.svh =====
// Assertion macros shared by the broadcast schedule RTL.
`ifndef BROADCAST_TREE_SCHEDULE_UNIT_DEFINES_SVH
`define BROADCAST_TREE_SCHEDULE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define BTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define BTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BTS_ASSERT_SAME(lbl, ante, cons, msg)
`define BTS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/bts_pkg.sv =====
// Types, constants and helper functions of the broadcast schedule unit.
package bts_pkg;

  // Group and field sizing.
  localparam int MAX_RANKS = 64;
  localparam int RANK_BITS = $clog2(MAX_RANKS);
  localparam int SIZE_BITS = RANK_BITS + 1;
  localparam int KIND_BITS = 2;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  // Register map, indexed by address bit 2.
  localparam logic REG_GROUP_SIZE    = 1'b0;
  localparam logic REG_SCHEDULE_KIND = 1'b1;

  // Reset values of the registers.
  localparam logic [SIZE_BITS-1:0] GROUP_SIZE_RST    = SIZE_BITS'(2);
  localparam logic [KIND_BITS-1:0] SCHEDULE_KIND_RST = KIND_BITS'(0);

  // Schedule codes; the unused code falls back to linear.
  typedef enum logic [KIND_BITS-1:0] {
    KIND_LINEAR   = 2'd0,
    KIND_BINOMIAL = 2'd1,
    KIND_RING     = 2'd2
  } kind_t;

  // Configuration as seen by the pipeline: clamped size and schedule.
  typedef struct packed {
    logic [SIZE_BITS-1:0] size;
    kind_t                kind;
  } cfg_t;

  // Stage 1 to stage 2: relative rank and range check.
  typedef struct packed {
    logic                 valid;
    logic                 err;
    logic [RANK_BITS-1:0] rel;
    logic [RANK_BITS-1:0] root;
  } rel_stage_t;

  // Stage 2 to stage 3: destinations and parent in relative rank space.
  typedef struct packed {
    logic                 valid;
    logic                 err;
    logic                 has_par;
    logic [RANK_BITS-1:0] par_rel;
    logic [MAX_RANKS-1:0] rel_mask;
    logic [RANK_BITS-1:0] root;
  } fan_stage_t;

  // Mask with bits 0 .. n-1 set, for n from 0 up to MAX_RANKS.
  function automatic logic [MAX_RANKS-1:0] low_mask(input logic [SIZE_BITS-1:0] n);
    logic [MAX_RANKS:0] one_hot;
    one_hot = (MAX_RANKS + 1)'(1) << n;
    return one_hot[MAX_RANKS-1:0] - MAX_RANKS'(1);
  endfunction

endpackage

// ===== rtl/bts_cfg_regs.sv =====
// APB register file holding the group size and the schedule kind.
module bts_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bts_pkg::ADDR_W-1:0] paddr,
  input  logic [bts_pkg::DATA_W-1:0] pwdata,
  output logic [bts_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output bts_pkg::cfg_t              cfg
);
  import bts_pkg::*;

  logic [SIZE_BITS-1:0] group_size;
  logic [KIND_BITS-1:0] schedule_kind;
  logic                 wr_en;
  logic                 reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_size    <= GROUP_SIZE_RST;
      schedule_kind <= SCHEDULE_KIND_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GROUP_SIZE:    group_size    <= pwdata[SIZE_BITS-1:0];
        REG_SCHEDULE_KIND: schedule_kind <= pwdata[KIND_BITS-1:0];
        default:           ;
      endcase
    end
  end

  // Read mux returns the raw register values.
  always_comb begin
    case (reg_idx)
      REG_GROUP_SIZE:    prdata = DATA_W'(group_size);
      REG_SCHEDULE_KIND: prdata = DATA_W'(schedule_kind);
      default:           prdata = '0;
    endcase
  end

  // A size above the largest group acts as the largest group.
  always_comb begin
    cfg.size = (group_size > SIZE_BITS'(MAX_RANKS)) ? SIZE_BITS'(MAX_RANKS) : group_size;
    cfg.kind = kind_t'(schedule_kind);
  end

endmodule

// ===== rtl/bts_rel_stage.sv =====
// Stage 1: range check and rank relative to the root.
module bts_rel_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  bts_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  input  logic [bts_pkg::RANK_BITS-1:0] node_rank,
  input  logic [bts_pkg::RANK_BITS-1:0] root_rank,
  output bts_pkg::rel_stage_t           s1
);
  import bts_pkg::*;

  logic                 err_next;
  logic [SIZE_BITS:0]   diff;
  logic [SIZE_BITS:0]   diff_wrap;
  logic [RANK_BITS-1:0] rel_next;

  // rel = (node - root) mod n, valid only when both ranks are in range.
  always_comb begin
    err_next  = ({1'b0, node_rank} >= cfg.size) || ({1'b0, root_rank} >= cfg.size);
    diff      = (SIZE_BITS + 1)'(node_rank) + (SIZE_BITS + 1)'(cfg.size)
              - (SIZE_BITS + 1)'(root_rank);
    diff_wrap = (diff >= (SIZE_BITS + 1)'(cfg.size)) ?
                diff - (SIZE_BITS + 1)'(cfg.size) : diff;
    rel_next  = diff_wrap[RANK_BITS-1:0];
  end

  // Valid bit is control state; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= in_valid;
    end
    s1.err  <= err_next;
    s1.rel  <= rel_next;
    s1.root <= root_rank;
  end

endmodule

// ===== rtl/bts_fanout_stage.sv =====
// Stage 2: destinations and parent of the node in relative rank space.
module bts_fanout_stage (
  input  logic                clk,
  input  logic                rst,
  input  bts_pkg::cfg_t       cfg,
  input  bts_pkg::rel_stage_t s1,
  output bts_pkg::fan_stage_t s2
);
  import bts_pkg::*;

  logic [MAX_RANKS-1:0] mask_next;
  logic                 has_par_next;
  logic [RANK_BITS-1:0] par_rel_next;
  logic [RANK_BITS-1:0] low_bit;
  logic [RANK_BITS-1:0] below;
  logic [SIZE_BITS-1:0] child;
  logic [SIZE_BITS-1:0] succ;

  always_comb begin
    mask_next    = '0;
    has_par_next = 1'b0;
    par_rel_next = '0;
    // Lowest set bit of rel, and the powers of two below it (all of them for the root).
    low_bit = s1.rel & (~s1.rel + RANK_BITS'(1));
    below   = (s1.rel == '0) ? '1 : low_bit - RANK_BITS'(1);
    succ    = {1'b0, s1.rel} + SIZE_BITS'(1);
    child   = '0;
    case (cfg.kind)
      // Ring: send to the next rank unless this is the last one.
      KIND_RING: begin
        if (succ < cfg.size) begin
          mask_next[succ[RANK_BITS-1:0]] = 1'b1;
        end
        has_par_next = (s1.rel != '0);
        par_rel_next = s1.rel - RANK_BITS'(1);
      end
      // Binomial: parent clears the lowest set bit; children add each lower power.
      KIND_BINOMIAL: begin
        for (int k = 0; k < RANK_BITS; k++) begin
          child = {1'b0, s1.rel} + (SIZE_BITS'(1) << k);
          if (below[k] && (child < cfg.size)) begin
            mask_next[child[RANK_BITS-1:0]] = 1'b1;
          end
        end
        has_par_next = (s1.rel != '0);
        par_rel_next = s1.rel - low_bit;
      end
      // Linear: the root reaches every other rank directly.
      default: begin
        if (s1.rel == '0) begin
          mask_next = low_mask(cfg.size) & ~MAX_RANKS'(1);
        end else begin
          has_par_next = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s1.valid;
    end
    s2.err      <= s1.err;
    s2.has_par  <= has_par_next;
    s2.par_rel  <= par_rel_next;
    s2.rel_mask <= mask_next;
    s2.root     <= s1.root;
  end

endmodule

// ===== rtl/bts_map_stage.sv =====
// Stage 3: rotate relative results back to absolute ranks and drive the outputs.
module bts_map_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  bts_pkg::cfg_t                 cfg,
  input  bts_pkg::fan_stage_t           s2,
  output logic                          done,
  output logic [bts_pkg::MAX_RANKS-1:0] dest_mask,
  output logic                          has_parent,
  output logic [bts_pkg::RANK_BITS-1:0] parent_rank,
  output logic                          range_error
);
  import bts_pkg::*;

  logic [SIZE_BITS-1:0] back_shift;
  logic [MAX_RANKS-1:0] abs_mask;
  logic [SIZE_BITS-1:0] par_sum;
  logic [SIZE_BITS-1:0] par_abs;

  // Rotate left by root within n bits: low part shifts up, wrapped part comes down.
  always_comb begin
    back_shift = cfg.size - {1'b0, s2.root};
    abs_mask   = ((s2.rel_mask << s2.root) & low_mask(cfg.size))
               | (s2.rel_mask >> back_shift);
    par_sum    = {1'b0, s2.par_rel} + {1'b0, s2.root};
    par_abs    = (par_sum >= cfg.size) ? par_sum - cfg.size : par_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2.valid;
    end
  end

  // An out-of-range request reports only the error flag.
  always_ff @(posedge clk) begin
    range_error <= s2.err;
    dest_mask   <= s2.err ? '0 : abs_mask;
    has_parent  <= !s2.err && s2.has_par;
    parent_rank <= (!s2.err && s2.has_par) ? par_abs[RANK_BITS-1:0] : '0;
  end

endmodule

// ===== rtl/broadcast_tree_schedule_unit.sv =====
// Top level of the broadcast fan-out schedule unit.
// A request is taken at every rising edge where start is high; busy is never raised, so a
// new request may follow in every cycle. Each request gives exactly one result, driven onto
// the result ports with done high once it has passed the registered stages in order (range
// check and relative rank, fan-out in relative space, rotation to absolute ranks). Results
// keep request order and cannot be held off by the receiver.
// The group size and schedule kind must only be written over APB while no request is in
// flight.
`include "broadcast_tree_schedule_unit_defines.svh"

module broadcast_tree_schedule_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bts_pkg::RANK_BITS-1:0] node_rank,
  input  logic [bts_pkg::RANK_BITS-1:0] root_rank,
  output logic                          done,
  output logic [bts_pkg::MAX_RANKS-1:0] dest_mask,
  output logic                          has_parent,
  output logic [bts_pkg::RANK_BITS-1:0] parent_rank,
  output logic                          range_error,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bts_pkg::ADDR_W-1:0]    paddr,
  input  logic [bts_pkg::DATA_W-1:0]    pwdata,
  output logic [bts_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import bts_pkg::*;

  cfg_t       cfg;
  rel_stage_t s1;
  fan_stage_t s2;
  logic       req_accept;

  // The pipeline takes a request every cycle.
  assign busy       = 1'b0;
  assign req_accept = start && !busy;

  bts_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bts_rel_stage u_rel (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (req_accept),
    .node_rank (node_rank),
    .root_rank (root_rank),
    .s1        (s1)
  );

  bts_fanout_stage u_fan (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .s1  (s1),
    .s2  (s2)
  );

  bts_map_stage u_map (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .s2          (s2),
    .done        (done),
    .dest_mask   (dest_mask),
    .has_parent  (has_parent),
    .parent_rank (parent_rank),
    .range_error (range_error)
  );

  // Checks on the pipeline and on result consistency.
  `BTS_ASSERT_NEXT(a_stage_to_done, s2.valid, done, "stage 2 request did not complete")
  `BTS_ASSERT_SAME(a_err_clean, done && range_error, (dest_mask == '0) && !has_parent && (parent_rank == '0), "range error result not empty")
  `BTS_ASSERT_SAME(a_parent_not_dest, done && has_parent, !dest_mask[parent_rank], "parent is also a destination")
  `BTS_ASSERT_SAME(a_dest_in_group, done, (dest_mask & ~low_mask(cfg.size)) == '0, "destination outside the group")

endmodule
